// ===== hw/rtl/buffer_slot_cache_macros.svh =====
// ----------------------------------------------------------------------------
// Buffer slot cache assertion macros
// Shared concurrent assertion wrappers for the buffer slot cache RTL.
// ----------------------------------------------------------------------------
`ifndef BUFFER_SLOT_CACHE_MACROS_SVH
`define BUFFER_SLOT_CACHE_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define BSC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("buffer slot cache assertion failed");

// Expression must never be true outside reset.
`define BSC_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("buffer slot cache forbidden condition seen");

`else

`define BSC_ASSERT(label, clk, rst, prop)
`define BSC_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== hw/rtl/bsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer slot cache package
// Field widths, action codes and the result record shared by the block.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int CACHE_DEPTH_DEF = 16;
   localparam int SEQ_W           = 32;
   localparam int CAP_W           = 5;
   localparam int SLOT_W          = 4;
   localparam int ACTION_W        = 2;
   localparam int FLUSH_W         = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SKIP   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SUBMIT = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                cache_hit;
      logic [SLOT_W-1:0]   slot_index;
      logic                slot_valid;
      logic                send_handle;
      logic [FLUSH_W-1:0]  flush_count;
      logic                clear_all;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bsc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer submission channel
// Valid/ready channel carrying one buffer submission per item.
// ----------------------------------------------------------------------------
interface bsc_req_if;
   logic                       valid;
   logic                       ready;
   logic                       buffer_present;
   logic [bsc_pkg::SEQ_W-1:0]  buffer_seq;
   logic                       compare_enable;
   logic                       same_as_previous;

   modport source (
      output valid, buffer_present, buffer_seq, compare_enable, same_as_previous,
      input  ready
   );
   modport sink (
      input  valid, buffer_present, buffer_seq, compare_enable, same_as_previous,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/bsc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot result channel
// Valid/ready channel carrying one slot decision per item.
// ----------------------------------------------------------------------------
interface bsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bsc_pkg::ACTION_W-1:0]  action;
   logic                          cache_hit;
   logic [bsc_pkg::SLOT_W-1:0]    slot_index;
   logic                          slot_valid;
   logic                          send_handle;
   logic [bsc_pkg::FLUSH_W-1:0]   flush_count;
   logic                          clear_all;

   modport source (
      output valid, action, cache_hit, slot_index, slot_valid, send_handle,
             flush_count, clear_all,
      input  ready
   );
   modport sink (
      input  valid, action, cache_hit, slot_index, slot_valid, send_handle,
             flush_count, clear_all,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/bsc_csr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Capacity register write channel
// Valid/ready write channel for the cache capacity register.
// ----------------------------------------------------------------------------
interface bsc_csr_if;
   logic                       valid;
   logic                       ready;
   logic [bsc_pkg::CAP_W-1:0]  cache_capacity;

   modport source (output valid, cache_capacity, input ready);
   modport sink   (input valid, cache_capacity, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/buffer_slot_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer slot cache
// Assigns display buffer submissions to cached slots by sequence number.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake      Carries
//  req_if    in         valid/ready    buffer_present, buffer_seq, compare_enable,
//                                      same_as_previous
//  rsp_if    out        valid/ready    action, cache_hit, slot_index, slot_valid,
//                                      send_handle, flush_count, clear_all
//  csr_if    in         valid/ready    cache_capacity
//
// An absent, skipped or zero-capacity item goes from accept straight to the done
// state. A submission scans the filled slots, ending early on a hit, and on a
// miss fills a slot; the slot memory's single read port scans one slot per cycle.
// One item is in work at a time; the next is accepted once the result is loaded
// into the output register, and a stalled result holds only that register.
// Reset is synchronous: capacity 16, empty table, next submission never skipped.
// ----------------------------------------------------------------------------
module buffer_slot_cache #(
   parameter int CacheDepth = bsc_pkg::CACHE_DEPTH_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bsc_req_if.sink     req_if,
   bsc_rsp_if.source   rsp_if,
   bsc_csr_if.sink     csr_if
);

   localparam int AddrW = (CacheDepth > 1) ? $clog2(CacheDepth) : 1;

   logic                      mem_rd_en;
   logic [AddrW-1:0]          mem_rd_addr;
   logic [bsc_pkg::SEQ_W-1:0] mem_rd_data;
   logic                      mem_wr_en;
   logic [AddrW-1:0]          mem_wr_addr;
   logic [bsc_pkg::SEQ_W-1:0] mem_wr_data;

   bsc_ctrl #(
      .CacheDepth (CacheDepth)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_if      (csr_if),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   bsc_slot_mem #(
      .CacheDepth (CacheDepth)
   ) u_slot_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/bsc_slot_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot sequence memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsc_slot_mem #(
   parameter int CacheDepth = bsc_pkg::CACHE_DEPTH_DEF
) (
   input  wire logic                                           clock,
   input  wire logic                                           rd_en,
   input  wire logic [((CacheDepth > 1) ? $clog2(CacheDepth) : 1)-1:0] rd_addr,
   output logic      [bsc_pkg::SEQ_W-1:0]                      rd_data,
   input  wire logic                                           wr_en,
   input  wire logic [((CacheDepth > 1) ? $clog2(CacheDepth) : 1)-1:0] wr_addr,
   input  wire logic [bsc_pkg::SEQ_W-1:0]                      wr_data
);

   logic [bsc_pkg::SEQ_W-1:0] mem_ff [CacheDepth];
   logic [bsc_pkg::SEQ_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bsc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer slot cache controller
// Decodes submissions, scans the slot memory and fills or flushes slots.
// ----------------------------------------------------------------------------
`include "buffer_slot_cache_macros.svh"

module bsc_ctrl #(
   parameter int CacheDepth = bsc_pkg::CACHE_DEPTH_DEF
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   bsc_req_if.sink                                             req_if,
   bsc_rsp_if.source                                           rsp_if,
   bsc_csr_if.sink                                             csr_if,
   output logic                                                mem_rd_en,
   output logic [((CacheDepth > 1) ? $clog2(CacheDepth) : 1)-1:0] mem_rd_addr,
   input  wire logic [bsc_pkg::SEQ_W-1:0]                      mem_rd_data,
   output logic                                                mem_wr_en,
   output logic [((CacheDepth > 1) ? $clog2(CacheDepth) : 1)-1:0] mem_wr_addr,
   output logic [bsc_pkg::SEQ_W-1:0]                           mem_wr_data
);

   localparam int AddrW = (CacheDepth > 1) ? $clog2(CacheDepth) : 1;
   localparam int CapW  = bsc_pkg::CAP_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_MISS = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CapW-1:0]           cap_ff, cap_in;
   logic [CapW-1:0]           fill_ff, fill_in;
   logic                      just_cleared_ff, just_cleared_in;
   logic [CapW-1:0]           next_ff, next_in;
   logic [CapW-1:0]           cmp_idx_ff, cmp_idx_in;
   logic                      rd_pend_ff, rd_pend_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [bsc_pkg::SEQ_W-1:0] seq_ff, seq_in;
   bsc_pkg::rsp_type          res_ff, res_in;
   bsc_pkg::rsp_type          rsp_ff, rsp_in;

   logic [CapW-1:0] cap_eff;
   logic [CapW-1:0] fill_clamp;
   logic            hit;
   logic            out_free;
   logic            accept;

   // Capacity values above the memory depth behave as the full depth.
   assign cap_eff    = (32'(cap_ff) > CacheDepth) ? CapW'(CacheDepth) : cap_ff;
   assign fill_clamp = (fill_ff > cap_eff) ? cap_eff : fill_ff;
   assign hit        = rd_pend_ff && (mem_rd_data == seq_ff);
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign accept     = req_if.valid && req_if.ready;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;

   always_comb begin
      state_in        = state_ff;
      cap_in          = cap_ff;
      fill_in         = fill_ff;
      just_cleared_in = just_cleared_ff;
      next_in         = next_ff;
      cmp_idx_in      = cmp_idx_ff;
      rd_pend_in      = rd_pend_ff;
      seq_in          = seq_ff;
      res_in          = res_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      mem_rd_en       = 1'b0;
      mem_rd_addr     = AddrW'(next_ff);
      mem_wr_en       = 1'b0;
      mem_wr_addr     = '0;
      mem_wr_data     = seq_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               seq_in = req_if.buffer_seq;
               res_in = '0;
               if (!req_if.buffer_present) begin
                  res_in.action = bsc_pkg::ACT_NONE;
                  state_in      = ST_DONE;
               end else if (req_if.compare_enable && req_if.same_as_previous &&
                            !just_cleared_ff) begin
                  res_in.action = bsc_pkg::ACT_SKIP;
                  state_in      = ST_DONE;
               end else if (cap_eff == '0) begin
                  res_in.action      = bsc_pkg::ACT_SUBMIT;
                  res_in.send_handle = 1'b1;
                  res_in.clear_all   = (fill_ff != '0);
                  fill_in            = '0;
                  just_cleared_in    = 1'b0;
                  state_in           = ST_DONE;
               end else begin
                  res_in.action     = bsc_pkg::ACT_SUBMIT;
                  res_in.slot_valid = 1'b1;
                  fill_in           = fill_clamp;
                  just_cleared_in   = 1'b0;
                  next_in           = '0;
                  rd_pend_in        = 1'b0;
                  state_in          = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Reads are issued one slot per cycle; the compare uses the registered read data.
            rd_pend_in = 1'b0;
            if (hit) begin
               res_in.cache_hit  = 1'b1;
               res_in.slot_index = bsc_pkg::SLOT_W'(cmp_idx_ff);
               state_in          = ST_DONE;
            end else if (next_ff < fill_ff) begin
               mem_rd_en  = 1'b1;
               rd_pend_in = 1'b1;
               cmp_idx_in = next_ff;
               next_in    = next_ff + 1'b1;
            end else begin
               state_in = ST_MISS;
            end
         end
         ST_MISS: begin
            res_in.send_handle = 1'b1;
            mem_wr_en          = 1'b1;
            if (fill_ff >= cap_eff) begin
               // Table full: every slot is dropped and the item restarts at slot zero.
               res_in.flush_count = fill_ff;
               res_in.slot_index  = '0;
               mem_wr_addr        = '0;
               fill_in            = CapW'(1);
            end else begin
               res_in.slot_index = bsc_pkg::SLOT_W'(fill_ff);
               mem_wr_addr       = AddrW'(fill_ff);
               fill_in           = fill_ff + 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_if.valid && csr_if.ready) begin
         cap_in          = csr_if.cache_capacity;
         fill_in         = '0;
         just_cleared_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cap_ff          <= bsc_pkg::CAP_RESET;
         fill_ff         <= '0;
         just_cleared_ff <= 1'b1;
         rd_pend_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cap_ff          <= cap_in;
         fill_ff         <= fill_in;
         just_cleared_ff <= just_cleared_in;
         rd_pend_ff      <= rd_pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      next_ff    <= next_in;
      cmp_idx_ff <= cmp_idx_in;
      seq_ff     <= seq_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.action      = rsp_ff.action;
   assign rsp_if.cache_hit   = rsp_ff.cache_hit;
   assign rsp_if.slot_index  = rsp_ff.slot_index;
   assign rsp_if.slot_valid  = rsp_ff.slot_valid;
   assign rsp_if.send_handle = rsp_ff.send_handle;
   assign rsp_if.flush_count = rsp_ff.flush_count;
   assign rsp_if.clear_all   = rsp_ff.clear_all;

   `BSC_ASSERT_NEVER(a_fill_within_cap, clock, reset, fill_ff > cap_eff)
   `BSC_ASSERT(a_miss_leaves_entry, clock, reset, (state_ff == ST_MISS) |=> (fill_ff != '0))
   `BSC_ASSERT(a_scan_within_fill, clock, reset, (state_ff == ST_SCAN) |-> (next_ff <= fill_ff))
   `BSC_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))

endmodule

`default_nettype wire
